### hdl/key_matrix_press_and_auto_repeat_defines.svh
// Assertion macros for the key matrix press and auto-repeat block.
// Used by the port checker; no other dependencies.
`ifndef KEY_MATRIX_PRESS_AND_AUTO_REPEAT_DEFINES_SVH
`define KEY_MATRIX_PRESS_AND_AUTO_REPEAT_DEFINES_SVH

// Checked only while out of reset.
`define KMPAR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define KMPAR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hdl/kmpar_pkg.sv
// Shared types and constants for the key matrix press and auto-repeat block.
// No dependencies.
package kmpar_pkg;

  localparam int unsigned KEY_W       = 6;   // width of key_levels / masks
  localparam int unsigned CNT_W       = 10;  // hold counter and register width
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 16;

  localparam int unsigned ROWS_DEF = 3;
  localparam int unsigned COLS_DEF = 2;

  localparam logic [CNT_W-1:0] LONG_PRESS_RST   = CNT_W'(500);
  localparam logic [CNT_W-1:0] REPEAT_START_RST = CNT_W'(5);
  localparam logic [CNT_W-1:0] REPEAT_STEP_RST  = CNT_W'(5);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LONG_PRESS_TICKS = 2'd0,
    REG_REPEAT_START     = 2'd1,
    REG_REPEAT_STEP      = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [CNT_W-1:0] long_press_ticks;
    logic [CNT_W-1:0] repeat_start;
    logic [CNT_W-1:0] repeat_step;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic             lng;
  } key_state_t;

endpackage

### hdl/kmpar_key_cell.sv
// Next-state rule for one key: hold counter, long-press flag and send pulse.
// Depends on kmpar_pkg.
module kmpar_key_cell (
  input  logic                    held_i,
  input  kmpar_pkg::cfg_t         cfg_i,
  input  kmpar_pkg::key_state_t   cur_i,
  output kmpar_pkg::key_state_t   nxt_o,
  output logic                    send_o
);

  logic [kmpar_pkg::CNT_W-1:0] inc;
  logic [kmpar_pkg::CNT_W:0]   sum;
  logic [kmpar_pkg::CNT_W:0]   sum_wrap;

  assign inc      = cur_i.cnt + kmpar_pkg::CNT_W'(1);
  assign sum      = {1'b0, cur_i.cnt} + {1'b0, cfg_i.repeat_step};
  // one subtraction of the limit only
  assign sum_wrap = (sum >= {1'b0, cfg_i.long_press_ticks}) ?
                    (sum - {1'b0, cfg_i.long_press_ticks}) : sum;

  always_comb begin
    nxt_o  = cur_i;
    send_o = 1'b0;
    priority if (held_i && (cur_i.cnt == '0)) begin
      send_o    = 1'b1;
      nxt_o.cnt = cur_i.lng ? cfg_i.repeat_start : kmpar_pkg::CNT_W'(1);
    end else if (held_i && !cur_i.lng) begin
      if (inc >= cfg_i.long_press_ticks) begin
        nxt_o.cnt = '0;
        nxt_o.lng = 1'b1;
      end else begin
        nxt_o.cnt = inc;
      end
    end else if (held_i) begin
      nxt_o.cnt = sum_wrap[kmpar_pkg::CNT_W-1:0];
    end else begin
      nxt_o = '0;
    end
  end

endmodule

### hdl/key_matrix_press_and_auto_repeat.sv
// Key matrix press detector with auto-repeat: input register, per-key cells, result register.
// Each input beat is held in the input register, then its result is held in the result register.
// Throughput: one scan tick per cycle; both stages advance whenever the result can move on.
// Reset (rst_ni low, async): pipeline empty, all hold counters and long flags cleared,
// registers back to long_press_ticks=500, repeat_start=5, repeat_step=5.
// Depends on kmpar_pkg and kmpar_key_cell.
module key_matrix_press_and_auto_repeat #(
  parameter int unsigned ROWS = kmpar_pkg::ROWS_DEF,
  parameter int unsigned COLS = kmpar_pkg::COLS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // config write port
  input  logic                                cfg_we_i,
  input  logic [kmpar_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [kmpar_pkg::CNT_W-1:0]         cfg_data_i,
  // input stream
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [kmpar_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,  // [5:0] key_levels, rest zero
  // result stream
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [kmpar_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o   // [5:0] send_mask, [11:6] long_mask
);

  localparam int unsigned NKEYS = ROWS * COLS;
  localparam int unsigned KW    = kmpar_pkg::KEY_W;

  kmpar_pkg::cfg_t cfg_q;

  logic          in_vld_q;
  logic [KW-1:0] lvl_q;
  logic          out_vld_q;
  logic [KW-1:0] send_q, long_q;
  logic [KW-1:0] send_d, long_d;
  logic          out_ready, s1_ready, s1_fire;

  kmpar_pkg::key_state_t st_q [NKEYS];
  kmpar_pkg::key_state_t st_d [NKEYS];
  logic [NKEYS-1:0]      send_all;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ticks <= kmpar_pkg::LONG_PRESS_RST;
      cfg_q.repeat_start     <= kmpar_pkg::REPEAT_START_RST;
      cfg_q.repeat_step      <= kmpar_pkg::REPEAT_STEP_RST;
    end else if (cfg_we_i) begin
      unique case (kmpar_pkg::cfg_reg_e'(cfg_idx_i))
        kmpar_pkg::REG_LONG_PRESS_TICKS: cfg_q.long_press_ticks <= cfg_data_i;
        kmpar_pkg::REG_REPEAT_START:     cfg_q.repeat_start     <= cfg_data_i;
        kmpar_pkg::REG_REPEAT_STEP:      cfg_q.repeat_step      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake: result register frees when taken, input stage moves into it
  assign out_ready       = !out_vld_q || m_axis_tready_i;
  assign s1_ready        = !in_vld_q || out_ready;
  assign s1_fire         = in_vld_q && out_ready;
  assign s_axis_tready_o = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s1_ready) in_vld_q <= s_axis_tvalid_i;
      if (out_ready) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && s_axis_tvalid_i) lvl_q <= s_axis_tdata_i[KW-1:0];
    if (s1_fire) begin
      send_q <= send_d;
      long_q <= long_d;
    end
  end

  // per-key cells; keys past the input width never read as held
  for (genvar k = 0; k < NKEYS; k++) begin : g_key
    logic held;
    if (k < KW) begin : g_in
      assign held = lvl_q[k];
    end else begin : g_none
      assign held = 1'b0;
    end

    kmpar_key_cell u_cell (
      .held_i (held),
      .cfg_i  (cfg_q),
      .cur_i  (st_q[k]),
      .nxt_o  (st_d[k]),
      .send_o (send_all[k])
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_q[k] <= '0;
      end else if (s1_fire) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  for (genvar i = 0; i < KW; i++) begin : g_mask
    if (i < NKEYS) begin : g_key_bit
      assign send_d[i] = send_all[i];
      assign long_d[i] = st_d[i].lng;
    end else begin : g_pad
      assign send_d[i] = 1'b0;
      assign long_d[i] = 1'b0;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {(kmpar_pkg::OUT_TDATA_W - 2*KW)'(0), long_q, send_q};

endmodule

### hdl/kmpar_checker.sv
// Port-level checks for the key matrix press and auto-repeat block, bound to the top level.
// Depends on kmpar_pkg and key_matrix_press_and_auto_repeat_defines.svh.
`include "key_matrix_press_and_auto_repeat_defines.svh"

module kmpar_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tready_o,
  input logic                               m_axis_tvalid_o,
  input logic                               m_axis_tready_i,
  input logic [kmpar_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o
);

  // no result beat may be shown while in reset
  `KMPAR_ASSERT_ALWAYS(a_rst_empty, !rst_ni |-> !m_axis_tvalid_o, "result valid during reset")

  // an empty result register never back-pressures the input
  `KMPAR_ASSERT(a_ready_when_empty, !m_axis_tvalid_o |-> s_axis_tready_o, "input stalled with empty output")

  // stalled result beat keeps its payload
  `KMPAR_ASSERT(a_hold_stall, m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o), "result changed while stalled")

  // padding above the two masks stays zero
  `KMPAR_ASSERT(a_pad_zero, m_axis_tvalid_o |-> (m_axis_tdata_o[kmpar_pkg::OUT_TDATA_W-1:2*kmpar_pkg::KEY_W] == '0), "nonzero tdata padding")

endmodule

bind key_matrix_press_and_auto_repeat kmpar_checker u_kmpar_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
